[rtl/core/cursor_overlay_with_palette_match_unit_defines.svh]
// Assertion macros shared by the cursor overlay checker.
`ifndef CURSOR_OVERLAY_WITH_PALETTE_MATCH_UNIT_DEFINES_SVH
`define CURSOR_OVERLAY_WITH_PALETTE_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define COPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cursor overlay check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define COPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cursor overlay check failed");

`endif

[rtl/core/copm_pkg.sv]
// Types, codes and the arrow cursor ROM for the cursor overlay unit.
package copm_pkg;

   localparam int unsigned DataW      = 32;
   localparam int unsigned CoordW     = 12;
   localparam int unsigned IndexW     = 8;
   localparam int unsigned RgbW       = 24;
   localparam int unsigned DistW      = 20;
   localparam int unsigned CsrIndexW  = 3;
   localparam int unsigned CursorCols = 12;
   localparam int unsigned CursorRows = 21;

   localparam logic [DistW-1:0]  DistStart       = 20'd1000000;
   localparam logic [IndexW-1:0] WhiteIndexReset = 8'd15;
   localparam logic [DataW-1:0]  TrueWhiteReset  = 32'h00FF_FFFF;

   // Request kinds
   localparam logic CmdPixel   = 1'b0;
   localparam logic CmdPalette = 1'b1;

   // Pixel depth codes; the unused code behaves as 32-bit
   localparam logic [1:0] Depth8  = 2'd0;
   localparam logic [1:0] Depth16 = 2'd1;
   localparam logic [1:0] Depth32 = 2'd2;

   // Register indexes on the csr port
   localparam logic [CsrIndexW-1:0] RegCursorLeft = 3'd0;
   localparam logic [CsrIndexW-1:0] RegCursorTop  = 3'd1;
   localparam logic [CsrIndexW-1:0] RegDepthMode  = 3'd2;
   localparam logic [CsrIndexW-1:0] RegTrueWhite  = 3'd3;
   localparam logic [CsrIndexW-1:0] RegTrueBlack  = 3'd4;

   // Cursor codes
   localparam logic [1:0] CodeClear = 2'd0;

   typedef struct packed {
      logic              command;
      logic [CoordW-1:0] pixel_col;
      logic [CoordW-1:0] pixel_row;
      logic [DataW-1:0]  background;
      logic [IndexW-1:0] entry_index;
      logic [RgbW-1:0]   entry_rgb;
   } req_item_type;

   // One arrow row, column c in bits 2c+1:2c (leftmost column at the right)
   function automatic logic [2*CursorCols-1:0] arrow_row(input logic [4:0] row);
      logic [2*CursorCols-1:0] bits;
      bits = '0;
      case (row)
         5'd0:  bits = 24'b00_00_00_00_00_00_00_00_00_00_00_10;
         5'd1:  bits = 24'b00_00_00_00_00_00_00_00_00_00_10_10;
         5'd2:  bits = 24'b00_00_00_00_00_00_00_00_00_10_01_10;
         5'd3:  bits = 24'b00_00_00_00_00_00_00_00_10_01_01_10;
         5'd4:  bits = 24'b00_00_00_00_00_00_00_10_01_01_01_10;
         5'd5:  bits = 24'b00_00_00_00_00_00_10_01_01_01_01_10;
         5'd6:  bits = 24'b00_00_00_00_00_10_01_01_01_01_01_10;
         5'd7:  bits = 24'b00_00_00_00_10_01_01_01_01_01_01_10;
         5'd8:  bits = 24'b00_00_00_10_01_01_01_01_01_01_01_10;
         5'd9:  bits = 24'b00_00_10_01_01_01_01_01_01_01_01_10;
         5'd10: bits = 24'b00_10_01_01_01_01_01_01_01_01_01_10;
         5'd11: bits = 24'b10_10_10_10_10_01_01_01_01_01_01_10;
         5'd12: bits = 24'b00_00_00_00_10_01_01_10_01_01_01_10;
         5'd13: bits = 24'b00_00_00_00_10_01_01_10_10_01_01_10;
         5'd14: bits = 24'b00_00_00_10_01_01_10_00_00_10_01_10;
         5'd15: bits = 24'b00_00_00_10_01_01_10_00_00_00_10_10;
         5'd16: bits = 24'b00_00_10_01_01_10_00_00_00_00_00_10;
         5'd17: bits = 24'b00_00_10_01_01_10_00_00_00_00_00_00;
         5'd18: bits = 24'b00_10_01_01_10_00_00_00_00_00_00_00;
         5'd19: bits = 24'b00_10_01_01_10_00_00_00_00_00_00_00;
         5'd20: bits = 24'b00_00_10_10_00_00_00_00_00_00_00_00;
         default: bits = '0;
      endcase
      return bits;
   endfunction

   // Square of an 8-bit channel difference
   function automatic logic [15:0] square8(input logic [7:0] value);
      return 16'(value) * 16'(value);
   endfunction

endpackage

[rtl/core/cursor_overlay_with_palette_match_unit.sv]
// Top level: arrow cursor overlay on a pixel stream with palette nearest-color search.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall command, pixel_col, pixel_row, background,
//                                           entry_index, entry_rgb
//   rsp      out        rsp_valid/rsp_stall pixel_out, cursor_hit (pixel requests only)
//   csr      in         csr_write           csr_index, csr_data
//
// One request per clock while req_stall is low; a pixel response is valid once it has
// passed the input register and then the result register.
// Both stages are single registers: input register, then result register; the
// cursor lookup and the palette distance compare sit between them.
// In 8-bit depth mode, palette requests update the search state as they leave the input register.
// Reset is synchronous; there is no clearing pass.
// A stalled response blocks only a pixel request held in the input register; palette requests there drain.
module cursor_overlay_with_palette_match_unit
   import copm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [CoordW-1:0]    req_pixel_col,
   input  logic [CoordW-1:0]    req_pixel_row,
   input  logic [DataW-1:0]     req_background,
   input  logic [IndexW-1:0]    req_entry_index,
   input  logic [RgbW-1:0]      req_entry_rgb,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DataW-1:0]     rsp_pixel_out,
   output logic                 rsp_cursor_hit,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [DataW-1:0]     csr_data
);

   // Configuration registers
   logic [CoordW-1:0] cursor_left_ff;
   logic [CoordW-1:0] cursor_top_ff;
   logic [1:0]        depth_mode_ff;
   logic [DataW-1:0]  true_white_ff;
   logic [DataW-1:0]  true_black_ff;

   // Palette search state
   logic [IndexW-1:0] white_index_ff, white_index_in;
   logic [IndexW-1:0] black_index_ff, black_index_in;
   logic [DistW-1:0]  best_white_ff, best_white_in;
   logic [DistW-1:0]  best_black_ff, best_black_in;

   // Pipeline registers
   logic              s1_valid_ff, s1_valid_in;
   req_item_type      s1_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic              rsp_hit_ff, rsp_hit_in;

   logic              s1_is_pixel;
   logic              out_free;
   logic              s1_advance;
   logic              req_accept;
   logic              search_update;

   logic [CoordW:0]   dx_full;
   logic [CoordW:0]   dy_full;
   logic              in_window;
   logic [2*CursorCols-1:0] row_bits;
   logic [1:0]        code;
   logic [DataW-1:0]  white_pix;
   logic [DataW-1:0]  black_pix;
   logic [DataW-1:0]  pix_mask;
   logic [DataW-1:0]  pix_raw;

   logic [7:0]        red, green, blue;
   logic [DistW-1:0]  dist_white;
   logic [DistW-1:0]  dist_black;
   logic [DistW-1:0]  base_white;
   logic [DistW-1:0]  base_black;

   // Handshake: a palette request leaves stage 1 without needing the result register
   assign s1_is_pixel = (s1_item_ff.command == CmdPixel);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = s1_valid_ff && (!s1_is_pixel || out_free);
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign req_accept  = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = (s1_advance && s1_is_pixel) || (rsp_valid_ff && rsp_stall);

   // Locate the pixel inside the cursor window; no wrap at the screen edge
   always_comb begin
      dx_full   = {1'b0, s1_item_ff.pixel_col} - {1'b0, cursor_left_ff};
      dy_full   = {1'b0, s1_item_ff.pixel_row} - {1'b0, cursor_top_ff};
      in_window = !dx_full[CoordW] && !dy_full[CoordW]
                  && (dx_full[CoordW-1:0] < CoordW'(CursorCols))
                  && (dy_full[CoordW-1:0] < CoordW'(CursorRows));
      row_bits  = arrow_row(dy_full[4:0]);
      code      = in_window ? row_bits[{dx_full[3:0], 1'b0} +: 2] : CodeClear;
   end

   // Pick colors and mask for the current depth
   always_comb begin
      case (depth_mode_ff)
         Depth8: begin
            white_pix = DataW'(white_index_ff);
            black_pix = DataW'(black_index_ff);
            pix_mask  = 32'h0000_00FF;
         end
         Depth16: begin
            white_pix = true_white_ff;
            black_pix = true_black_ff;
            pix_mask  = 32'h0000_FFFF;
         end
         default: begin
            white_pix = true_white_ff;
            black_pix = true_black_ff;
            pix_mask  = 32'hFFFF_FFFF;
         end
      endcase
   end

   // Overlay: low code bit draws white, else high bit draws black
   always_comb begin
      rsp_hit_in = 1'b1;
      pix_raw    = s1_item_ff.background;
      if (code[0]) begin
         pix_raw = white_pix;
      end else if (code[1]) begin
         pix_raw = black_pix;
      end else begin
         rsp_hit_in = 1'b0;
      end
      rsp_pixel_in = pix_raw & pix_mask;
   end

   // Squared RGB distance to white and to black
   always_comb begin
      red        = s1_item_ff.entry_rgb[7:0];
      green      = s1_item_ff.entry_rgb[15:8];
      blue       = s1_item_ff.entry_rgb[23:16];
      dist_white = DistW'(square8(~red)) + DistW'(square8(~green))
                   + DistW'(square8(~blue));
      dist_black = DistW'(square8(red)) + DistW'(square8(green)) + DistW'(square8(blue));
   end

   // Running search; entry zero restarts it, strict less-than keeps the first minimum
   assign search_update = s1_advance && !s1_is_pixel && (depth_mode_ff == Depth8);

   always_comb begin
      base_white     = (s1_item_ff.entry_index == '0) ? DistStart : best_white_ff;
      base_black     = (s1_item_ff.entry_index == '0) ? DistStart : best_black_ff;
      best_white_in  = base_white;
      white_index_in = white_index_ff;
      best_black_in  = base_black;
      black_index_in = black_index_ff;
      if (dist_white < base_white) begin
         best_white_in  = dist_white;
         white_index_in = s1_item_ff.entry_index;
      end
      if (dist_black < base_black) begin
         best_black_in  = dist_black;
         black_index_in = s1_item_ff.entry_index;
      end
   end

   // Control and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         white_index_ff <= WhiteIndexReset;
         black_index_ff <= '0;
         best_white_ff  <= DistStart;
         best_black_ff  <= DistStart;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (search_update) begin
            white_index_ff <= white_index_in;
            black_index_ff <= black_index_in;
            best_white_ff  <= best_white_in;
            best_black_ff  <= best_black_in;
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_left_ff <= '0;
         cursor_top_ff  <= '0;
         depth_mode_ff  <= Depth8;
         true_white_ff  <= TrueWhiteReset;
         true_black_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            RegCursorLeft: cursor_left_ff <= csr_data[CoordW-1:0];
            RegCursorTop:  cursor_top_ff  <= csr_data[CoordW-1:0];
            RegDepthMode:  depth_mode_ff  <= csr_data[1:0];
            RegTrueWhite:  true_white_ff  <= csr_data;
            RegTrueBlack:  true_black_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= '{command:     req_command,
                         pixel_col:   req_pixel_col,
                         pixel_row:   req_pixel_row,
                         background:  req_background,
                         entry_index: req_entry_index,
                         entry_rgb:   req_entry_rgb};
      end
      if (s1_advance && s1_is_pixel) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_hit_ff   <= rsp_hit_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_cursor_hit = rsp_hit_ff;

endmodule

[rtl/core/copm_checker.sv]
// Port-level checker for the cursor overlay unit, bound to the top level.
`include "cursor_overlay_with_palette_match_unit_defines.svh"

module copm_checker
   import copm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [DataW-1:0] rsp_pixel_out,
   input logic             rsp_cursor_hit
);

   // Hold a stalled response
   `COPM_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Keep a stalled response payload steady
   `COPM_ASSERT_NEXT(rsp_stable_a, clock, reset, rsp_valid && rsp_stall,
                     $stable(rsp_pixel_out) && $stable(rsp_cursor_hit))

   // Stall requests only behind a blocked response
   `COPM_ASSERT_NOW(req_stall_cause_a, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Drop responses and request stall on reset
   `COPM_ASSERT_NEXT(reset_clear_a, clock, 1'b0, reset, !rsp_valid && !req_stall)

endmodule

bind cursor_overlay_with_palette_match_unit copm_checker u_copm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_out  (rsp_pixel_out),
   .rsp_cursor_hit (rsp_cursor_hit)
);
